/* hw/rtl/nerve_stimulation_response_filter_defines.svh */
// assertion macros for the nerve stimulation response filter
// used by files that hold concurrent assertions; expects clk and arst_n in scope
`ifndef NERVE_STIMULATION_RESPONSE_FILTER_DEFINES_SVH
`define NERVE_STIMULATION_RESPONSE_FILTER_DEFINES_SVH

// condition in the same cycle
`define NSRF_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// condition in the next cycle
`define NSRF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hw/rtl/nsrf_pkg.sv */
// shared constants for the nerve stimulation response filter
// no dependencies
`timescale 1ns / 1ps

package nsrf_pkg;

	// default sizes
	localparam int DEF_MAX_TAPS          = 1024;
	localparam int DEF_SAMPLE_BITS       = 20;
	localparam int DEF_TAP_FRACTION_BITS = 24;

	// register widths
	localparam int RATIO_W = 16;
	localparam int GAIN_W  = 32;
	localparam int RESP_W  = 32;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register indexes
	localparam logic REG_RATIO = 1'b0;
	localparam logic REG_GAIN  = 1'b1;

	// register reset values
	localparam logic [RATIO_W-1:0] RATIO_RST = 16'd528;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 32'd65536;

	// saturation limits
	localparam logic [RESP_W-1:0] RESP_MAX = 32'h7fff_ffff;
	localparam logic [RESP_W-1:0] RESP_MIN = 32'h8000_0000;

endpackage

/* hw/rtl/nsrf_in_if.sv */
// input channel: one three-axis slew sample per item
// depends on nsrf_pkg
`timescale 1ns / 1ps

interface nsrf_in_if #(
	parameter int SAMPLE_BITS = nsrf_pkg::DEF_SAMPLE_BITS
) ();
	logic                          valid;
	logic                          ready;
	logic                          first;
	logic signed [SAMPLE_BITS-1:0] slew_x;
	logic signed [SAMPLE_BITS-1:0] slew_y;
	logic signed [SAMPLE_BITS-1:0] slew_z;

	modport source (output valid, first, slew_x, slew_y, slew_z, input ready);
	modport sink (input valid, first, slew_x, slew_y, slew_z, output ready);
endinterface

/* hw/rtl/nsrf_out_if.sv */
// output channel: three axis responses and a saturation flag per item
// depends on nsrf_pkg
`timescale 1ns / 1ps

interface nsrf_out_if ();
	import nsrf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [RESP_W-1:0] response_x;
	logic signed [RESP_W-1:0] response_y;
	logic signed [RESP_W-1:0] response_z;
	logic                     saturated;

	modport source (output valid, response_x, response_y, response_z, saturated,
		input ready);
	modport sink (input valid, response_x, response_y, response_z, saturated,
		output ready);
endinterface

/* hw/rtl/nerve_stimulation_response_filter.sv */
// nerve stimulation response filter: kernel build, convolution and scaling
// depends on nsrf_pkg, nsrf_in_if, nsrf_out_if, nerve_stimulation_response_filter_defines.svh
//
//  channel    | dir | handshake      | payload
//  samples    | in  | valid / ready  | first, slew_x, slew_y, slew_z
//  responses  | out | valid / ready  | response_x, response_y, response_z, saturated
//  apb        | in  | psel / penable | paddr, pwdata, pwrite -> prdata, pready
//
// each item runs one tap per cycle through the three multiply-accumulate lanes,
// over min(history, kernel length) taps, then six passes of the shared gain
// multiplier; samples.ready stays low until the item is done. after reset and
// after each chronaxie_ratio write the tap table is rebuilt by the serial
// divider, with samples.ready low. a result waiting in the output register
// stalls the next item only in its final state.
`timescale 1ns / 1ps

module nerve_stimulation_response_filter #(
	parameter int MAX_TAPS          = nsrf_pkg::DEF_MAX_TAPS,
	parameter int SAMPLE_BITS       = nsrf_pkg::DEF_SAMPLE_BITS,
	parameter int TAP_FRACTION_BITS = nsrf_pkg::DEF_TAP_FRACTION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	nsrf_in_if.sink                       samples,
	nsrf_out_if.source                    responses,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nsrf_pkg::PADDR_W-1:0]  paddr,
	input  logic [nsrf_pkg::PDATA_W-1:0]  pwdata,
	output logic [nsrf_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import nsrf_pkg::*;

	localparam int TFB   = TAP_FRACTION_BITS;
	localparam int PTR_W = $clog2(MAX_TAPS);
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int AW    = ((PTR_W + 4 > RATIO_W) ? PTR_W + 4 : RATIO_W) + 1;
	localparam int DW    = 2 * AW;
	localparam int NW    = RATIO_W + TFB + 4;
	localparam int SW    = DW + TFB;
	localparam int CW    = (NW > SW) ? NW : SW;
	localparam int QC_W  = $clog2(TFB);
	localparam int LR_W  = RATIO_W + 3;
	localparam int MW    = TFB + SAMPLE_BITS + 1;
	localparam int ACC_W = MW + CNT_W;
	localparam int LO_W  = ACC_W / 2;
	localparam int OP_W  = LO_W + 1;
	localparam int PW    = OP_W + GAIN_W + 1;
	localparam int FW    = ACC_W + GAIN_W + 1;
	localparam int SH    = TFB + 8;
	localparam int HW    = 3 * SAMPLE_BITS;
	localparam int LEN_RAW_RST = (5 * 528) / 4 + 1;
	localparam int LEN_RST = (LEN_RAW_RST > MAX_TAPS) ? MAX_TAPS : LEN_RAW_RST;

	// sequencer states
	localparam logic [2:0] ST_BMUL  = 3'd0;
	localparam logic [2:0] ST_BPREP = 3'd1;
	localparam logic [2:0] ST_BDIV  = 3'd2;
	localparam logic [2:0] ST_IDLE  = 3'd3;
	localparam logic [2:0] ST_CONV  = 3'd4;
	localparam logic [2:0] ST_SCALE = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	localparam logic [2:0] SC_LAST = 3'd6;

	function automatic logic [CNT_W-1:0] kern_len(input logic [RATIO_W-1:0] r);
		logic [LR_W-1:0] raw;
		raw = ((LR_W'(r) * LR_W'(5)) >> 2) + LR_W'(1);
		if (raw > LR_W'(MAX_TAPS))
			return CNT_W'(MAX_TAPS);
		return CNT_W'(raw);
	endfunction

	logic [2:0]          state_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [CNT_W-1:0]    len_q;

	// kernel build
	logic [CNT_W-1:0]    bi_q;
	logic [DW-1:0]       den_q;
	logic [NW-1:0]       rem_q;
	logic [SW-1:0]       dsh_q;
	logic [TFB-1:0]      quo_q;
	logic [QC_W-1:0]     qc_q;
	logic [AW-1:0]       a_w;
	logic                ge_w;
	logic [TFB-1:0]      tap_w;

	// history and convolution
	logic [HW-1:0]       hist_mem [MAX_TAPS];
	logic [TFB-1:0]      tap_mem [MAX_TAPS];
	logic [PTR_W-1:0]    wp_q;
	logic [PTR_W-1:0]    rp_q;
	logic [PTR_W-1:0]    wp_n;
	logic [CNT_W-1:0]    seen_q;
	logic [CNT_W-1:0]    seen_base;
	logic [CNT_W-1:0]    seen_n;
	logic [CNT_W-1:0]    k_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                issue_w;
	logic                v_s1;
	logic                v_s2;
	logic [TFB-1:0]      tap_s1;
	logic [HW-1:0]       hist_s1;
	logic signed [MW-1:0]    prod_s2 [3];
	logic signed [ACC_W-1:0] acc_q [3];

	// gain scaling
	logic [2:0]              sc_q;
	logic [1:0]              sc_axis;
	logic signed [ACC_W-1:0] sc_acc;
	logic signed [OP_W-1:0]  mop;
	logic signed [PW-1:0]    gprod_s1;
	logic [1:0]              gaxis_s1;
	logic                    ghalf_s1;
	logic                    gv_s1;
	logic signed [PW-1:0]    sacc_q;
	logic signed [FW-1:0]    full_w;
	logic [FW-SH-32:0]       top_w;
	logic [RESP_W-1:0]       clip_w;
	logic                    clipped_w;
	logic [RESP_W-1:0]       res_q [3];
	logic                    sat_q;

	logic                    out_v_q;
	logic                    accept;
	logic                    cfg_wr;

	assign accept = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE) && !cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// register readback
	always_comb begin
		unique case (paddr[2])
			REG_GAIN:  prdata = gain_q;
			default:   prdata = PDATA_W'(ratio_q);
		endcase
	end

	// divider datapath
	assign a_w = AW'(ratio_q) + AW'({bi_q, 4'b0000});
	assign ge_w = CW'(rem_q) >= CW'(dsh_q);
	assign tap_w = (den_q == '0) ? '0 : {quo_q[TFB-2:0], ge_w};

	// ring pointers and fill count
	assign wp_n = (wp_q == PTR_W'(MAX_TAPS - 1)) ? '0 : wp_q + PTR_W'(1);
	assign seen_base = samples.first ? '0 : seen_q;
	assign seen_n = (seen_base == CNT_W'(MAX_TAPS)) ? seen_base : seen_base + CNT_W'(1);
	assign issue_w = (state_q == ST_CONV) && (k_q != cnt_q);

	// scaling operand select
	assign sc_axis = sc_q[2:1];
	always_comb begin
		unique case (sc_axis)
			2'd0:    sc_acc = acc_q[0];
			2'd1:    sc_acc = acc_q[1];
			default: sc_acc = acc_q[2];
		endcase
		if (sc_q[0])
			mop = OP_W'($signed(sc_acc[ACC_W-1:LO_W]));
		else
			mop = $signed({1'b0, sc_acc[LO_W-1:0]});
	end

	// recombine halves, floor shift and clip
	always_comb begin
		full_w = FW'(sacc_q) + (FW'(gprod_s1) <<< LO_W);
		top_w = full_w[FW-1:SH+31];
		clipped_w = !((&top_w) || !(|top_w));
		if (!clipped_w)
			clip_w = full_w[SH+31:SH];
		else if (full_w[FW-1])
			clip_w = RESP_MIN;
		else
			clip_w = RESP_MAX;
	end

	// memories
	always_ff @(posedge clk) begin
		if (accept)
			hist_mem[wp_n] <= {samples.slew_z, samples.slew_y, samples.slew_x};
		if (state_q == ST_BDIV && qc_q == '0)
			tap_mem[bi_q[PTR_W-1:0]] <= tap_w;
		tap_s1 <= tap_mem[k_q[PTR_W-1:0]];
		hist_s1 <= hist_mem[rp_q];
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++)
			prod_s2[l] <= $signed({1'b0, tap_s1}) *
				$signed(hist_s1[l*SAMPLE_BITS +: SAMPLE_BITS]);
		gprod_s1 <= mop * $signed({1'b0, gain_q});
		gaxis_s1 <= sc_axis;
		ghalf_s1 <= sc_q[0];
		if (state_q == ST_BMUL)
			den_q <= DW'(a_w) * DW'(a_w + AW'(16));
	end

	// control and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BMUL;
			ratio_q <= RATIO_RST;
			gain_q <= GAIN_RST;
			len_q <= CNT_W'(LEN_RST);
			bi_q <= '0;
			rem_q <= '0;
			dsh_q <= '0;
			quo_q <= '0;
			qc_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
			seen_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sc_q <= '0;
			gv_s1 <= 1'b0;
			sacc_q <= '0;
			sat_q <= 1'b0;
			out_v_q <= 1'b0;
			for (int l = 0; l < 3; l++) begin
				acc_q[l] <= '0;
				res_q[l] <= '0;
			end
		end else begin
			v_s1 <= issue_w;
			v_s2 <= v_s1;
			gv_s1 <= (state_q == ST_SCALE) && (sc_q != SC_LAST);
			if (responses.valid && responses.ready)
				out_v_q <= 1'b0;

			// lane accumulate
			if (v_s2)
				for (int l = 0; l < 3; l++)
					acc_q[l] <= acc_q[l] + ACC_W'(prod_s2[l]);

			// gain product halves
			if (gv_s1) begin
				if (!ghalf_s1)
					sacc_q <= gprod_s1;
				else begin
					res_q[gaxis_s1] <= clip_w;
					if (clipped_w)
						sat_q <= 1'b1;
				end
			end

			unique case (state_q)
				ST_BMUL: begin
					state_q <= ST_BPREP;
				end
				ST_BPREP: begin
					rem_q <= NW'({ratio_q, (TFB + 4)'(0)});
					dsh_q <= SW'(den_q) << (TFB - 1);
					qc_q <= QC_W'(TFB - 1);
					state_q <= ST_BDIV;
				end
				ST_BDIV: begin
					if (ge_w)
						rem_q <= rem_q - NW'(dsh_q);
					quo_q <= {quo_q[TFB-2:0], ge_w};
					dsh_q <= dsh_q >> 1;
					qc_q <= qc_q - QC_W'(1);
					if (qc_q == '0) begin
						bi_q <= bi_q + CNT_W'(1);
						state_q <= (bi_q + CNT_W'(1) == len_q) ? ST_IDLE : ST_BMUL;
					end
				end
				ST_IDLE: begin
					if (accept && !cfg_wr) begin
						wp_q <= wp_n;
						rp_q <= wp_n;
						seen_q <= seen_n;
						cnt_q <= (seen_n < len_q) ? seen_n : len_q;
						k_q <= '0;
						sat_q <= 1'b0;
						for (int l = 0; l < 3; l++)
							acc_q[l] <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (issue_w) begin
						k_q <= k_q + CNT_W'(1);
						rp_q <= (rp_q == '0) ? PTR_W'(MAX_TAPS - 1) : rp_q - PTR_W'(1);
					end else if (!v_s1 && !v_s2) begin
						sc_q <= '0;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					sc_q <= sc_q + 3'd1;
					if (sc_q == SC_LAST)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_v_q || responses.ready) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// register writes, a ratio write restarts the kernel build
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
					default: begin
						ratio_q <= pwdata[RATIO_W-1:0];
						len_q <= kern_len(pwdata[RATIO_W-1:0]);
						bi_q <= '0;
						state_q <= ST_BMUL;
					end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!out_v_q || responses.ready)) begin
			responses.response_x <= res_q[0];
			responses.response_y <= res_q[1];
			responses.response_z <= res_q[2];
			responses.saturated <= sat_q;
		end
	end
	assign responses.valid = out_v_q;

	`include "nerve_stimulation_response_filter_defines.svh"

	`NSRF_ASSERT_NEXT(a_accept_starts_conv, accept && !cfg_wr, state_q == ST_CONV, "item accepted but convolution not started")
	`NSRF_ASSERT_NOW(a_conv_count_range, state_q == ST_CONV, cnt_q != '0 && cnt_q <= len_q && cnt_q <= seen_q, "tap count out of range")
	`NSRF_ASSERT_NOW(a_len_range, state_q == ST_IDLE, len_q != '0 && len_q <= CNT_W'(MAX_TAPS), "kernel length out of range")
	`NSRF_ASSERT_NOW(a_result_from_fin, $rose(out_v_q), $past(state_q) == ST_FIN, "result loaded outside final state")
	`NSRF_ASSERT_NOW(a_no_scale_during_conv, state_q == ST_CONV, !gv_s1, "gain pass overlaps convolution")

endmodule

/* dv/nsrf_tb_if.sv */
// no testbench interfaces of its own: the channels use the rtl interfaces
// nsrf_in_if and nsrf_out_if, which depend on nsrf_pkg
`timescale 1ns / 1ps

package nsrf_tb_types;
	import nsrf_pkg::*;

	// one expected response item
	typedef struct packed {
		logic signed [RESP_W-1:0] x;
		logic signed [RESP_W-1:0] y;
		logic signed [RESP_W-1:0] z;
		logic                     sat;
	} resp_item_t;
endpackage

/* dv/tb.sv */
// testbench for nerve_stimulation_response_filter: random and directed slew items,
// responses checked against a convolution predictor; depends on nsrf_pkg,
// nsrf_in_if, nsrf_out_if and nsrf_tb_types
`timescale 1ns / 1ps

class response_scoreboard;
	localparam int TAPS = nsrf_pkg::DEF_MAX_TAPS;
	localparam int TFB  = nsrf_pkg::DEF_TAP_FRACTION_BITS;

	nsrf_tb_types::resp_item_t expected_q[$];
	longint unsigned tap[TAPS];
	longint          hist[3][TAPS];
	int              taps_used;
	int              seen;
	logic [15:0]     ratio;
	logic [31:0]     gain;
	int              mismatches;

	function new();
		ratio = nsrf_pkg::RATIO_RST;
		gain = nsrf_pkg::GAIN_RST;
		seen = 0;
		mismatches = 0;
		foreach (hist[a, k]) hist[a][k] = 0;
		rebuild_taps();
	endfunction

	// kernel c/((c+i)(c+i+1)) with c = ratio/16, in Q0.24
	function void rebuild_taps();
		longint unsigned r;
		longint unsigned len;
		longint unsigned a;
		longint unsigned den;
		r = ratio;
		len = (5 * r) / 4 + 1;
		if (len > TAPS) len = TAPS;
		taps_used = int'(len);
		for (int i = 0; i < TAPS; i++) begin
			a = r + 16 * i;
			den = a * (a + 16);
			tap[i] = (i < len && den != 0) ? (r << (TFB + 4)) / den : 0;
		end
	endfunction

	function void set_ratio(logic [15:0] v);
		ratio = v;
		rebuild_taps();
	endfunction

	function void set_gain(logic [31:0] v);
		gain = v;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// convolve one axis, scale, floor and clip
	function logic signed [31:0] axis_resp(int axis, int cnt, inout logic sat);
		logic signed [127:0] acc;
		logic signed [127:0] g;
		logic signed [127:0] sh;
		acc = 0;
		g = {96'd0, gain};
		for (int k = 0; k < cnt; k++) acc += $signed(tap[k]) * hist[axis][k];
		sh = (acc * g) >>> (TFB + 8);
		if (sh > 128'sh7fff_ffff) begin
			sat = 1'b1;
			return nsrf_pkg::RESP_MAX;
		end
		if (sh < -128'sh8000_0000) begin
			sat = 1'b1;
			return nsrf_pkg::RESP_MIN;
		end
		return sh[31:0];
	endfunction

	// accepted sample item: update history, queue the expected response
	function void note_sample(logic first, logic signed [19:0] sx, logic signed [19:0] sy,
			logic signed [19:0] sz);
		nsrf_tb_types::resp_item_t e;
		int cnt;
		logic sat;
		if (first) seen = 0;
		for (int k = TAPS - 1; k > 0; k--)
			for (int a = 0; a < 3; a++) hist[a][k] = hist[a][k-1];
		hist[0][0] = sx;
		hist[1][0] = sy;
		hist[2][0] = sz;
		if (seen < TAPS) seen++;
		cnt = seen < taps_used ? seen : taps_used;
		sat = 1'b0;
		e.x = axis_resp(0, cnt, sat);
		e.y = axis_resp(1, cnt, sat);
		e.z = axis_resp(2, cnt, sat);
		e.sat = sat;
		expected_q.push_back(e);
	endfunction

	// accepted response item against the oldest expectation
	function void check_response(nsrf_tb_types::resp_item_t got);
		nsrf_tb_types::resp_item_t e;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected response x=%0d y=%0d z=%0d sat=%0b",
				got.x, got.y, got.z, got.sat);
			return;
		end
		e = expected_q.pop_front();
		if (got !== e) begin
			mismatches++;
			if (mismatches <= 10)
				$display("response mismatch: exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
					e.x, e.y, e.z, e.sat, got.x, got.y, got.z, got.sat);
		end
	endfunction
endclass

module tb;
	import nsrf_pkg::*;

	localparam int WATCHDOG_LIMIT = 100000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic              pready;

	bit idle_on;
	bit holdoff_req;
	int quiet_cycles;
	response_scoreboard sb;

	nsrf_in_if  samples ();
	nsrf_out_if responses ();

	nerve_stimulation_response_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples.sink),
		.responses (responses.source),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// monitor both channels
	always @(posedge clk) begin
		if (arst_n && samples.valid && samples.ready)
			sb.note_sample(samples.first, samples.slew_x, samples.slew_y, samples.slew_z);
		if (arst_n && responses.valid && responses.ready)
			sb.check_response({responses.response_x, responses.response_y,
				responses.response_z, responses.saturated});
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (responses.valid && responses.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// response side ready with bursts of idling and one long hold-off
	initial begin
		responses.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				responses.ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				responses.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				responses.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// stop offering items and wait until every expected response is back
	task automatic wait_drained();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write, block idle
	task automatic reg_write(logic idx, logic [31:0] v);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_RATIO) sb.set_ratio(v[15:0]);
		else sb.set_gain(v);
	endtask

	task automatic send_sample(logic first, logic [19:0] sx, logic [19:0] sy, logic [19:0] sz);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.first <= first;
		samples.slew_x <= sx;
		samples.slew_y <= sy;
		samples.slew_z <= sz;
		do @(negedge clk); while (!samples.ready);
		@(posedge clk);
	endtask

	function automatic logic [19:0] rand_slew();
		case ($urandom_range(0, 3))
			0: return 20'($signed($urandom_range(0, 64)) - 32);
			1: return $urandom_range(0, 1) ? 20'h7ffff : 20'h80000;
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, 1024);
			1: return $urandom_range(1 << 14, 1 << 18);
			2: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_block(int n);
		for (int i = 0; i < n; i++)
			send_sample(i == 0 || $urandom_range(0, 19) == 0, rand_slew(), rand_slew(), rand_slew());
	endtask

	// stimulus
	initial begin
		sb = new();
		idle_on = 1'b1;
		holdoff_req = 1'b0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		samples.valid <= 1'b0;
		samples.first <= 1'b0;
		samples.slew_x <= '0;
		samples.slew_y <= '0;
		samples.slew_z <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes at reset settings, short history
		send_sample(1'b1, 20'h7ffff, 20'h80000, 20'h00000);
		send_sample(1'b0, 20'h7ffff, 20'h80000, 20'h00001);
		send_sample(1'b0, 20'h80000, 20'h7ffff, 20'hfffff);
		send_sample(1'b1, 20'h00000, 20'h00000, 20'h7ffff);
		send_sample(1'b0, 20'h55555, 20'haaaaa, 20'h80000);
		// ratio change mid-waveform keeps history
		reg_write(REG_RATIO, 32'h0001_0010);
		send_sample(1'b0, 20'h7ffff, 20'h7ffff, 20'h7ffff);
		send_sample(1'b0, 20'h80000, 20'h80000, 20'h80000);
		// largest gain saturates
		reg_write(REG_GAIN, 32'hffff_ffff);
		send_sample(1'b0, 20'h7ffff, 20'h80000, 20'h00000);
		send_sample(1'b1, 20'h80000, 20'h00001, 20'hfffff);
		// zero gain
		reg_write(REG_GAIN, 32'd0);
		send_sample(1'b1, 20'h7ffff, 20'h80000, 20'h12345);
		send_sample(1'b0, 20'h7ffff, 20'h80000, 20'h12345);
		// zero ratio: single zero tap
		reg_write(REG_GAIN, 32'd65536);
		reg_write(REG_RATIO, 32'd0);
		send_sample(1'b1, 20'h7ffff, 20'h80000, 20'h7ffff);
		send_sample(1'b0, 20'h80000, 20'h7ffff, 20'h80000);
		// smallest nonzero ratio and largest ratio
		reg_write(REG_RATIO, 32'd1);
		send_sample(1'b1, 20'h7ffff, 20'h80000, 20'h00010);
		send_sample(1'b0, 20'h7ffff, 20'h80000, 20'h00010);
		reg_write(REG_RATIO, 32'd65535);
		reg_write(REG_GAIN, 32'd1);
		send_sample(1'b1, 20'h7ffff, 20'h80000, 20'h7ffff);
		send_sample(1'b0, 20'h7ffff, 20'h80000, 20'h7ffff);
		send_sample(1'b0, 20'h80000, 20'h7ffff, 20'h00000);

		// random phases with varied settings
		for (int p = 0; p < 9; p++) begin
			reg_write(REG_RATIO, $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
				: $urandom_range(1, 400));
			reg_write(REG_GAIN, rand_gain());
			if (p == 3) holdoff_req = 1'b1;
			if (p == 5) begin
				send_block(31);
				wait_drained();
			end
			if (p == 8) idle_on = 1'b0;
			send_block(p == 5 ? 31 : 62);
		end

		wait_drained();
		repeat (1100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
